@@ src/evad_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// evad_pkg
// Shared widths, constants and controller/datapath interface types for the
// energy voice activity detector.
// ----------------------------------------------------------------------------
package evad_pkg;

    // Field and state widths
    localparam int SAMPLE_W    = 16;
    localparam int THRESH_W    = 16;
    localparam int FLEN_W      = 12;
    localparam int LIMIT_W     = 8;
    localparam int COUNT_W     = 8;
    localparam int FRAMES_W    = 16;
    localparam int ENERGY_W    = 16;
    localparam int SUM_W       = 27;

    // Longest frame in samples; longer settings are clamped to it
    localparam int MAX_FRAME_SAMPLES = 2048;

    // Divider: one quotient bit per step over the whole dividend
    localparam int DIV_STEPS   = SUM_W;
    localparam int DIV_STEP_W  = $clog2(DIV_STEPS);

    // Configuration port
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;

    // Register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_SPEECH_LEVEL      = 3'd0,
        REG_FRAME_LENGTH      = 3'd1,
        REG_SILENCE_LIMIT     = 3'd2,
        REG_MIN_SPEECH_FRAMES = 3'd3,
        REG_BUFFER_ALL_MODE   = 3'd4
    } reg_index_t;

    // Reset values of the registers
    localparam logic [THRESH_W-1:0] THRESH_RST = 16'd300;
    localparam logic [FLEN_W-1:0]   FLEN_RST   = 12'd480;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 8'd26;
    localparam logic [COUNT_W-1:0]  MIN_RST    = 8'd8;

    // Request operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [THRESH_W-1:0] speech_level;
        logic [FLEN_W-1:0]   frame_length;
        logic [LIMIT_W-1:0]  silence_limit;
        logic [COUNT_W-1:0]  min_speech_frames;
        logic                buffer_all_mode;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;    // capture the accepted request
        logic accum;      // add magnitude, count sample, arm divider at frame end
        logic div_step;   // one restoring division step
        logic decide;     // classify frame, update utterance, load result
        logic flush_out;  // load flush result, clear utterance
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic frame_end;  // the sample in accumulation closes the frame
        logic div_last;   // division step in progress is the final one
        logic out_free;   // result register can take a new result
        logic buf_empty;  // no frames buffered
    } dp_sts_t;

endpackage : evad_pkg
`default_nettype wire

@@ src/evad_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// evad_ctrl
// Sequencer: accepts one request at a time and steps the datapath through
// accumulation, at frame end also division and frame decision, or through a flush.
// ----------------------------------------------------------------------------
module evad_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_operation,
    input  wire evad_pkg::dp_sts_t sts,
    output evad_pkg::dp_cmd_t     cmd
);
    import evad_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_ACCUM  = 5'b00010,
        ST_DIVIDE = 5'b00100,
        ST_DECIDE = 5'b01000,
        ST_FLUSH  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = (s_operation == OP_FLUSH) ? ST_FLUSH : ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = sts.frame_end ? ST_DIVIDE : ST_IDLE;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                // hold until the result register frees up
                if (sts.out_free) begin
                    cmd.decide = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (sts.buf_empty) begin
                    state_next = ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.flush_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule : evad_ctrl
`default_nettype wire

@@ src/evad_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// evad_dp
// Datapath: magnitude accumulation, bit-serial frame energy divider,
// utterance counters and the result register.
// ----------------------------------------------------------------------------
module evad_dp (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire evad_pkg::cfg_t                        cfg,
    input  wire evad_pkg::dp_cmd_t                     cmd,
    output evad_pkg::dp_sts_t                          sts,
    input  wire logic signed [evad_pkg::SAMPLE_W-1:0]  s_sample,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic                                       m_frame_speech,
    output logic                                       m_frame_buffered,
    output logic                                       m_utterance_ready,
    output logic                                       m_utterance_dropped,
    output logic [evad_pkg::FRAMES_W-1:0]              m_utterance_frames,
    output logic [evad_pkg::ENERGY_W-1:0]              m_frame_energy
);
    import evad_pkg::*;

    // Captured sample and frame accumulation
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [SUM_W-1:0]      abs_sum_reg;
    logic [FLEN_W-1:0]     cnt_reg;

    // Divider
    logic [SUM_W-1:0]      div_q_reg;
    logic [FLEN_W-1:0]     div_rem_reg;
    logic [FLEN_W-1:0]     div_d_reg;
    logic [DIV_STEP_W-1:0] div_step_reg;

    // Utterance state
    logic [LIMIT_W-1:0]    silent_run_reg;
    logic [COUNT_W-1:0]    speech_count_reg;
    logic                  in_speech_reg;
    logic [FRAMES_W-1:0]   buffered_reg;

    // Result register
    logic                  m_valid_reg;
    logic                  m_speech_reg;
    logic                  m_buffered_reg;
    logic                  m_ready_reg;
    logic                  m_dropped_reg;
    logic [FRAMES_W-1:0]   m_frames_reg;
    logic [ENERGY_W-1:0]   m_energy_reg;

    // Accumulation terms
    logic [SAMPLE_W-1:0]   mag;
    logic [SUM_W-1:0]      sum_new;
    logic [FLEN_W-1:0]     cnt_new;
    logic [FLEN_W-1:0]     eff_len;

    // Divider step terms
    logic [FLEN_W:0]       rem_sh;
    logic [FLEN_W+1:0]     rem_diff;
    logic                  rem_ge;

    // Decision terms
    logic [ENERGY_W-1:0]   energy;
    logic                  speech;
    logic                  joined;
    logic [FRAMES_W-1:0]   buffered_new;
    logic [LIMIT_W-1:0]    silent_new;
    logic                  utt_end;
    logic                  utt_ok;

    // Magnitude of the captured sample, the most negative value gives 32768
    assign mag     = sample_reg[SAMPLE_W-1] ? (~sample_reg + 1'b1) : sample_reg;
    assign sum_new = abs_sum_reg + SUM_W'(mag);
    assign cnt_new = cnt_reg + 1'b1;

    // Frame length clamped to one sample at least and the frame maximum
    always_comb begin
        if (cfg.frame_length == '0) begin
            eff_len = FLEN_W'(1);
        end else if (32'(cfg.frame_length) > MAX_FRAME_SAMPLES) begin
            eff_len = FLEN_W'(MAX_FRAME_SAMPLES);
        end else begin
            eff_len = cfg.frame_length;
        end
    end

    // Restoring division step
    assign rem_sh   = {div_rem_reg, div_q_reg[SUM_W-1]};
    assign rem_diff = {1'b0, rem_sh} - {2'b00, div_d_reg};
    assign rem_ge   = ~rem_diff[FLEN_W+1];

    // Frame classification and utterance bookkeeping
    assign energy       = (|div_q_reg[SUM_W-1:ENERGY_W]) ? '1 : div_q_reg[ENERGY_W-1:0];
    assign speech       = energy > cfg.speech_level;
    assign joined       = cfg.buffer_all_mode | speech | in_speech_reg;
    assign buffered_new = (joined && buffered_reg != '1) ? buffered_reg + 1'b1 : buffered_reg;
    assign silent_new   = (silent_run_reg != '1) ? silent_run_reg + 1'b1 : silent_run_reg;
    assign utt_end      = !speech && in_speech_reg && (silent_new >= cfg.silence_limit);
    assign utt_ok       = speech_count_reg >= cfg.min_speech_frames;

    // Status
    assign sts.frame_end = (cnt_new != '0) && (cnt_new >= eff_len);
    assign sts.div_last  = div_step_reg == DIV_STEP_W'(DIV_STEPS - 1);
    assign sts.out_free  = !m_valid_reg || m_ready;
    assign sts.buf_empty = buffered_reg == '0;

    // Capture the request payload
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            sample_reg <= s_sample;
        end
    end

    // Accumulate and arm the divider at frame end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            abs_sum_reg <= '0;
            cnt_reg     <= '0;
        end else if (cmd.accum) begin
            if (sts.frame_end) begin
                abs_sum_reg <= '0;
                cnt_reg     <= '0;
            end else begin
                abs_sum_reg <= sum_new;
                cnt_reg     <= cnt_new;
            end
        end
    end

    // Divide: dividend shifts out the top while quotient bits shift in
    always_ff @(posedge aclk) begin
        if (cmd.accum && sts.frame_end) begin
            div_q_reg    <= sum_new;
            div_rem_reg  <= '0;
            div_d_reg    <= cnt_new;
            div_step_reg <= '0;
        end else if (cmd.div_step) begin
            div_q_reg    <= {div_q_reg[SUM_W-2:0], rem_ge};
            div_rem_reg  <= rem_ge ? rem_diff[FLEN_W-1:0] : rem_sh[FLEN_W-1:0];
            div_step_reg <= div_step_reg + 1'b1;
        end
    end

    // Utterance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            silent_run_reg   <= '0;
            speech_count_reg <= '0;
            in_speech_reg    <= 1'b0;
            buffered_reg     <= '0;
        end else if (cmd.flush_out) begin
            silent_run_reg   <= '0;
            speech_count_reg <= '0;
            in_speech_reg    <= 1'b0;
            buffered_reg     <= '0;
        end else if (cmd.decide) begin
            if (utt_end) begin
                silent_run_reg   <= '0;
                speech_count_reg <= '0;
                in_speech_reg    <= 1'b0;
                buffered_reg     <= '0;
            end else if (speech) begin
                if (speech_count_reg != '1) begin
                    speech_count_reg <= speech_count_reg + 1'b1;
                end
                in_speech_reg  <= 1'b1;
                silent_run_reg <= '0;
                buffered_reg   <= buffered_new;
            end else begin
                if (in_speech_reg) begin
                    silent_run_reg <= silent_new;
                end
                buffered_reg <= buffered_new;
            end
        end
    end

    // Result valid: set on load, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.decide || cmd.flush_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            m_speech_reg   <= speech;
            m_buffered_reg <= joined;
            m_ready_reg    <= utt_end && utt_ok;
            m_dropped_reg  <= utt_end && !utt_ok;
            m_frames_reg   <= utt_end ? buffered_new : '0;
            m_energy_reg   <= energy;
        end else if (cmd.flush_out) begin
            m_speech_reg   <= 1'b0;
            m_buffered_reg <= 1'b0;
            m_ready_reg    <= 1'b1;
            m_dropped_reg  <= 1'b0;
            m_frames_reg   <= buffered_reg;
            m_energy_reg   <= '0;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_frame_speech      = m_speech_reg;
    assign m_frame_buffered    = m_buffered_reg;
    assign m_utterance_ready   = m_ready_reg;
    assign m_utterance_dropped = m_dropped_reg;
    assign m_utterance_frames  = m_frames_reg;
    assign m_frame_energy      = m_energy_reg;

endmodule : evad_dp
`default_nettype wire

@@ src/energy_voice_activity_detector.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// energy_voice_activity_detector
// Frame energy voice activity detector with hangover: classifies frames of
// audio samples as speech and reports utterances as ready or dropped.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                         Direction  Moves
//  s_        s_valid/s_ready + payload     in         sample or flush request
//  m_        m_valid/m_ready + payload     out        frame or utterance result
//  APB       psel/penable/pwrite/paddr...  in         register access
//
//  A mid-frame sample is accepted and accumulated; a frame-closing sample is
//  also divided and decided: the energy divider is bit-serial and yields one
//  quotient bit per cycle over the 27-bit magnitude sum. A flush is accepted
//  and then flushed. A new request is accepted while a result waits in the
//  output register; decide and a non-empty flush hold while it is full.
//  Reset (aresetn low, synchronous) clears control, accumulation, utterance,
//  result-valid and register state at once; no clearing pass.
module energy_voice_activity_detector (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // request channel
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_operation,
    input  wire logic signed [evad_pkg::SAMPLE_W-1:0]  s_sample,
    // result channel
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic                                       m_frame_speech,
    output logic                                       m_frame_buffered,
    output logic                                       m_utterance_ready,
    output logic                                       m_utterance_dropped,
    output logic [evad_pkg::FRAMES_W-1:0]              m_utterance_frames,
    output logic [evad_pkg::ENERGY_W-1:0]              m_frame_energy,
    // configuration port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [evad_pkg::PADDR_W-1:0]          paddr,
    input  wire logic [evad_pkg::PDATA_W-1:0]          pwdata,
    output logic [evad_pkg::PDATA_W-1:0]               prdata,
    output logic                                       pready
);
    import evad_pkg::*;

    logic [THRESH_W-1:0] thresh_reg;
    logic [FLEN_W-1:0]   flen_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [COUNT_W-1:0]  min_reg;
    logic                mode_reg;

    logic                wr_en;
    reg_index_t          reg_idx;
    cfg_t                cfg;
    dp_cmd_t             cmd;
    dp_sts_t             sts;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_index_t'(paddr[PADDR_W-1:2]);

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RST;
            flen_reg   <= FLEN_RST;
            limit_reg  <= LIMIT_RST;
            min_reg    <= MIN_RST;
            mode_reg   <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SPEECH_LEVEL:      thresh_reg <= pwdata[THRESH_W-1:0];
                REG_FRAME_LENGTH:      flen_reg   <= pwdata[FLEN_W-1:0];
                REG_SILENCE_LIMIT:     limit_reg  <= pwdata[LIMIT_W-1:0];
                REG_MIN_SPEECH_FRAMES: min_reg    <= pwdata[COUNT_W-1:0];
                REG_BUFFER_ALL_MODE:   mode_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (reg_idx)
            REG_SPEECH_LEVEL:      prdata = PDATA_W'(thresh_reg);
            REG_FRAME_LENGTH:      prdata = PDATA_W'(flen_reg);
            REG_SILENCE_LIMIT:     prdata = PDATA_W'(limit_reg);
            REG_MIN_SPEECH_FRAMES: prdata = PDATA_W'(min_reg);
            REG_BUFFER_ALL_MODE:   prdata = PDATA_W'(mode_reg);
            default:               prdata = '0;
        endcase
    end

    assign cfg.speech_level      = thresh_reg;
    assign cfg.frame_length      = flen_reg;
    assign cfg.silence_limit     = limit_reg;
    assign cfg.min_speech_frames = min_reg;
    assign cfg.buffer_all_mode   = mode_reg;

    evad_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .sts         (sts),
        .cmd         (cmd)
    );

    evad_dp u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg                 (cfg),
        .cmd                 (cmd),
        .sts                 (sts),
        .s_sample            (s_sample),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_frame_speech      (m_frame_speech),
        .m_frame_buffered    (m_frame_buffered),
        .m_utterance_ready   (m_utterance_ready),
        .m_utterance_dropped (m_utterance_dropped),
        .m_utterance_frames  (m_utterance_frames),
        .m_frame_energy      (m_frame_energy)
    );

endmodule : energy_voice_activity_detector
`default_nettype wire

@@ src/evad_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// evad_checker
// Port-level checks for the energy voice activity detector, bound to the
// top level.
// ----------------------------------------------------------------------------
module evad_checker (
    input wire logic                                  aclk,
    input wire logic                                  aresetn,
    input wire logic                                  s_valid,
    input wire logic                                  s_ready,
    input wire logic                                  m_valid,
    input wire logic                                  m_ready,
    input wire logic                                  m_frame_speech,
    input wire logic                                  m_frame_buffered,
    input wire logic                                  m_utterance_ready,
    input wire logic                                  m_utterance_dropped,
    input wire logic [evad_pkg::FRAMES_W-1:0]         m_utterance_frames,
    input wire logic [evad_pkg::ENERGY_W-1:0]         m_frame_energy
);

    // Hold a stalled result
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_utterance_frames)
                                && $stable(m_frame_energy))
        else $error("result changed while stalled");

    // Drop result valid during reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // One request at a time: busy right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted back to back");

    // Ready and dropped never together
    a_ready_xor_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_utterance_ready && m_utterance_dropped))
        else $error("utterance both ready and dropped");

    // A speech frame always joins the buffer
    a_speech_buffered: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_speech |-> m_frame_buffered)
        else $error("speech frame not buffered");

endmodule : evad_checker

bind energy_voice_activity_detector evad_checker u_evad_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .s_valid             (s_valid),
    .s_ready             (s_ready),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_frame_speech      (m_frame_speech),
    .m_frame_buffered    (m_frame_buffered),
    .m_utterance_ready   (m_utterance_ready),
    .m_utterance_dropped (m_utterance_dropped),
    .m_utterance_frames  (m_utterance_frames),
    .m_frame_energy      (m_frame_energy)
);
`default_nettype wire
